// ===== rtl/xor_checked_frame_packer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the xor-checked frame packer
// Shared concurrent check forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_PACKER_CORE_DEFINES_SVH
`define XOR_CHECKED_FRAME_PACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define XCFP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define XCFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/xcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfp_pkg
// Types, register indexes, frame constants and sequencer steps of the packer.
// ----------------------------------------------------------------------------
package xcfp_pkg;

    // frame marker bytes and length overhead
    localparam logic [7:0] HDR_A        = 8'hAA;
    localparam logic [7:0] HDR_B        = 8'h55;
    localparam logic [7:0] LEN_OVERHEAD = 8'd4;

    // configuration register indexes
    localparam int unsigned REG_ADDR_W = 3;
    localparam logic [REG_ADDR_W-1:0] REG_PAYLOAD_LENGTH = 3'd0;
    localparam logic [REG_ADDR_W-1:0] REG_LOCAL_ID       = 3'd1;
    localparam logic [REG_ADDR_W-1:0] REG_DESTINATION_ID = 3'd2;
    localparam logic [REG_ADDR_W-1:0] REG_ACK_REQUEST    = 3'd3;
    localparam logic [REG_ADDR_W-1:0] REG_FUNCTION_CODE  = 3'd4;

    // register reset values
    localparam logic [7:0] RST_PAYLOAD_LENGTH = 8'd1;

    // byte sequencer steps, in frame order
    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_SYNC_A   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SYNC_B   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LEN      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LOCAL    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DEST     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ACK      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FUNC     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_PAYLOAD  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_PARITY   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_TRAIL_B  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_TRAIL_A  = 4'd10;

    typedef struct packed {
        logic [7:0] payload_length;
        logic [7:0] local_id;
        logic [7:0] destination_id;
        logic [7:0] ack_request;
        logic [7:0] function_code;
    } cfg_t;

    // one accepted payload byte with everything needed to emit its bytes
    typedef struct packed {
        logic       first;
        logic       last;
        logic [7:0] len_byte;
        logic [7:0] local_id;
        logic [7:0] destination_id;
        logic [7:0] ack_request;
        logic [7:0] function_code;
        logic [7:0] payload_byte;
        logic [7:0] parity;
    } job_t;

    typedef struct packed {
        logic              busy;
        logic              out_free;
        logic [STEP_W-1:0] step;
    } seq_status_t;

endpackage

// ===== rtl/xcfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// xcfp_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module xcfp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [xcfp_pkg::REG_ADDR_W-1:0]    cfg_addr,
    input  logic [7:0]                         cfg_wdata,
    output xcfp_pkg::cfg_t                     cfg
);

    xcfp_pkg::cfg_t cfg_reg;
    xcfp_pkg::cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                xcfp_pkg::REG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_wdata;
                xcfp_pkg::REG_LOCAL_ID:       cfg_next.local_id       = cfg_wdata;
                xcfp_pkg::REG_DESTINATION_ID: cfg_next.destination_id = cfg_wdata;
                xcfp_pkg::REG_ACK_REQUEST:    cfg_next.ack_request    = cfg_wdata;
                xcfp_pkg::REG_FUNCTION_CODE:  cfg_next.function_code  = cfg_wdata;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.payload_length <= xcfp_pkg::RST_PAYLOAD_LENGTH;
            cfg_reg.local_id       <= '0;
            cfg_reg.destination_id <= '0;
            cfg_reg.ack_request    <= '0;
            cfg_reg.function_code  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/xcfp_frame_track.sv =====
// ----------------------------------------------------------------------------
// xcfp_frame_track
// Frame position and running parity; builds the job for each payload byte.
// ----------------------------------------------------------------------------
module xcfp_frame_track (
    input  logic             aclk,
    input  logic             aresetn,
    input  xcfp_pkg::cfg_t   cfg,
    input  logic [7:0]       payload_byte,
    input  logic             take,
    output xcfp_pkg::job_t   job
);

    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] parity_reg;
    logic [7:0] parity_next;

    logic       is_first;
    logic       is_last;
    logic [7:0] count_inc;
    logic [7:0] len_byte;
    logic [7:0] seed;
    logic [7:0] parity_new;

    // parity seed is the XOR of the header field bytes on the first byte of a frame
    always_comb begin
        is_first   = (count_reg == 8'd0);
        len_byte   = cfg.payload_length + xcfp_pkg::LEN_OVERHEAD;
        seed       = is_first ? (len_byte ^ cfg.local_id ^ cfg.destination_id ^
                                 cfg.ack_request ^ cfg.function_code)
                              : parity_reg;
        parity_new = seed ^ payload_byte;
        count_inc  = count_reg + 8'd1;
        is_last    = (count_inc == cfg.payload_length);
    end

    // job handed to the byte sequencer
    always_comb begin
        job.first          = is_first;
        job.last           = is_last;
        job.len_byte       = len_byte;
        job.local_id       = cfg.local_id;
        job.destination_id = cfg.destination_id;
        job.ack_request    = cfg.ack_request;
        job.function_code  = cfg.function_code;
        job.payload_byte   = payload_byte;
        job.parity         = parity_new;
    end

    // frame state update on each transfer
    always_comb begin
        count_next  = count_reg;
        parity_next = parity_reg;
        if (take) begin
            count_next  = is_last ? 8'd0 : count_inc;
            parity_next = is_last ? 8'd0 : parity_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            parity_reg <= '0;
        end else begin
            count_reg  <= count_next;
            parity_reg <= parity_next;
        end
    end

endmodule

// ===== rtl/xcfp_byte_seq.sv =====
// ----------------------------------------------------------------------------
// xcfp_byte_seq
// Holds one job and steps through its header, payload and trailer bytes
// into the output register, one byte per cycle while the output is free.
// ----------------------------------------------------------------------------
module xcfp_byte_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  xcfp_pkg::job_t          job_in,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_frame_byte,
    output logic                    m_frame_end,
    output xcfp_pkg::seq_status_t   status
);

    xcfp_pkg::job_t              job_reg;
    xcfp_pkg::job_t              job_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic [xcfp_pkg::STEP_W-1:0] step_reg;
    logic [xcfp_pkg::STEP_W-1:0] step_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic [7:0]                  byte_reg;
    logic [7:0]                  byte_next;
    logic                        end_reg;
    logic                        end_next;

    logic                        out_free;
    logic                        emit;
    logic                        job_done;
    logic                        take;
    logic [xcfp_pkg::STEP_W-1:0] end_step;
    logic [7:0]                  cur_byte;

    // handshake and step control
    always_comb begin
        out_free = !valid_reg || m_ready;
        end_step = job_reg.last ? xcfp_pkg::STEP_TRAIL_A : xcfp_pkg::STEP_PAYLOAD;
        emit     = busy_reg && out_free;
        job_done = emit && (step_reg == end_step);
        in_ready = !busy_reg || job_done;
        take     = in_valid && in_ready;
    end

    // byte select for the current step
    always_comb begin
        case (step_reg)
            xcfp_pkg::STEP_SYNC_A:  cur_byte = xcfp_pkg::HDR_A;
            xcfp_pkg::STEP_SYNC_B:  cur_byte = xcfp_pkg::HDR_B;
            xcfp_pkg::STEP_LEN:     cur_byte = job_reg.len_byte;
            xcfp_pkg::STEP_LOCAL:   cur_byte = job_reg.local_id;
            xcfp_pkg::STEP_DEST:    cur_byte = job_reg.destination_id;
            xcfp_pkg::STEP_ACK:     cur_byte = job_reg.ack_request;
            xcfp_pkg::STEP_FUNC:    cur_byte = job_reg.function_code;
            xcfp_pkg::STEP_PAYLOAD: cur_byte = job_reg.payload_byte;
            xcfp_pkg::STEP_PARITY:  cur_byte = job_reg.parity;
            xcfp_pkg::STEP_TRAIL_B: cur_byte = xcfp_pkg::HDR_B;
            xcfp_pkg::STEP_TRAIL_A: cur_byte = xcfp_pkg::HDR_A;
            default:                cur_byte = xcfp_pkg::HDR_A;
        endcase
    end

    // next state of job holder and output register
    always_comb begin
        job_next   = take ? job_in : job_reg;
        busy_next  = busy_reg;
        step_next  = step_reg;
        if (take) begin
            busy_next = 1'b1;
            step_next = job_in.first ? xcfp_pkg::STEP_SYNC_A : xcfp_pkg::STEP_PAYLOAD;
        end else if (job_done) begin
            busy_next = 1'b0;
        end else if (emit) begin
            step_next = step_reg + 4'd1;
        end

        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        if (emit) begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            end_next   = (step_reg == xcfp_pkg::STEP_TRAIL_A);
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            step_reg  <= xcfp_pkg::STEP_SYNC_A;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    assign m_valid         = valid_reg;
    assign m_frame_byte    = byte_reg;
    assign m_frame_end     = end_reg;
    assign status.busy     = busy_reg;
    assign status.out_free = out_free;
    assign status.step     = step_reg;

endmodule

// ===== rtl/xor_checked_frame_packer_core.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_packer_core
// Packs payload bytes into AA 55 framed messages with an XOR parity byte.
// ----------------------------------------------------------------------------
// Each payload byte transfer yields one output byte per cycle, unless the
// output stalls: eight for the first byte of a frame (seven header bytes plus
// the byte), four for the byte that completes it (the byte, parity, 55, AA),
// eleven for a byte that both opens and completes a frame, and one for all
// others. The output byte register is the rate limit: the input accepts a new
// byte in the cycle its predecessor's last output byte is loaded, so mid-frame
// bytes flow at one per cycle when the output is free, and the input stalls
// only while header or trailer bytes go out or the output stalls. A transfer
// is held in the job register before its first byte enters the output register.
// Header fields and the parity seed are taken from the registers on the first
// payload byte of a frame; a payload length of zero gives 256-byte payloads.
// ----------------------------------------------------------------------------
`include "xor_checked_frame_packer_core_defines.svh"

module xor_checked_frame_packer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [xcfp_pkg::REG_ADDR_W-1:0]   cfg_addr,
    input  logic [7:0]                        cfg_wdata,
    // payload input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_payload_byte,
    // framed output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_frame_byte,
    output logic                              m_frame_end
);

    xcfp_pkg::cfg_t        cfg;
    xcfp_pkg::job_t        job;
    xcfp_pkg::seq_status_t seq_status;
    logic                  take;

    assign take = s_valid && s_ready;

    // configuration registers
    xcfp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // frame position and parity
    xcfp_frame_track u_frame_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .payload_byte (s_payload_byte),
        .take         (take),
        .job          (job)
    );

    // byte sequencer and output register
    xcfp_byte_seq u_byte_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_in       (job),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_end  (m_frame_end),
        .status       (seq_status)
    );

    // frame end is only ever flagged on the closing AA
    `XCFP_ASSERT_NOW(a_end_on_aa, aclk, aresetn, m_valid && m_frame_end, m_frame_byte == xcfp_pkg::HDR_A, "frame end not on AA")
    // a held job blocks new transfers while the output is stalled
    `XCFP_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, seq_status.busy && !seq_status.out_free, !s_ready, "input taken during output stall")
    // sequencer step never runs past the closing AA
    `XCFP_ASSERT_NOW(a_step_range, aclk, aresetn, seq_status.busy, seq_status.step <= xcfp_pkg::STEP_TRAIL_A, "sequencer step out of range")
    // an accepted byte is held by the sequencer on the next cycle
    `XCFP_ASSERT_NEXT(a_take_emits, aclk, aresetn, s_valid && s_ready, seq_status.busy, "accepted byte not held")

endmodule
